// ===== design/bwmc_pkg.sv =====
`timescale 1ns / 1ps

package bwmc_pkg;

    // Word store geometry.
    localparam int WORD_SLOTS   = 8192;
    localparam int ADDR_W       = $clog2(WORD_SLOTS);
    localparam int WORD_W       = 24;

    // Bucket table geometry and field widths.
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int SLOT_W       = 13;
    localparam int COUNT_W      = 14;
    localparam int CHAR_W       = 8;

    // Request modes.
    localparam logic [1:0] MODE_DESC  = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Letter range for bucket selection.
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7a;

    // One bucket descriptor.
    typedef struct packed {
        logic [SLOT_W-1:0]  start;
        logic [COUNT_W-1:0] count;
    } t_desc;

    // Descriptor write command.
    typedef struct packed {
        logic                en;
        logic [LETTER_W-1:0] letter;
        t_desc               desc;
    } t_desc_wr;

endpackage

// ===== design/bwmc_word_ram.sv =====
`timescale 1ns / 1ps

module bwmc_word_ram #(
    parameter int DEPTH  = 8192,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/bwmc_bucket_table.sv =====
`timescale 1ns / 1ps

module bwmc_bucket_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bwmc_pkg::t_desc_wr                i_wr,
    input  logic [bwmc_pkg::LETTER_W-1:0]     i_rd_letter,
    output bwmc_pkg::t_desc                   o_rd_desc
);

    bwmc_pkg::t_desc r_desc [bwmc_pkg::LETTER_COUNT];

    // Descriptor registers; reset leaves every bucket empty at slot zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bwmc_pkg::LETTER_COUNT; k++) begin
                r_desc[k] <= '0;
            end
        end else if (i_wr.en &&
                     ({1'b0, i_wr.letter} < (bwmc_pkg::LETTER_W + 1)'(bwmc_pkg::LETTER_COUNT)))
        begin
            r_desc[i_wr.letter] <= i_wr.desc;
        end
    end

    // Out-of-range letters read as an empty bucket.
    always_comb begin
        o_rd_desc = '0;
        if ({1'b0, i_rd_letter} < (bwmc_pkg::LETTER_W + 1)'(bwmc_pkg::LETTER_COUNT)) begin
            o_rd_desc = r_desc[i_rd_letter];
        end
    end

endmodule

// ===== design/bucketed_word_membership_check_core.sv =====
`timescale 1ns / 1ps

// Dictionary of four-letter words held as three trailing bytes per slot,
// grouped into per-letter buckets that are each a sorted run of slots.
// The request channel (i_req_valid / o_req_ready) carries a mode and the
// payload fields. Mode 0 writes a bucket descriptor, mode 1 writes one
// stored word, mode 2 queries a word. Every request yields exactly one
// response on o_rsp_valid / i_rsp_ready with o_found and o_mode_echo.
// One request is in service at a time. Writes, the unused mode and queries
// that miss the letter range or hit an empty bucket go from acceptance
// straight to the DONE state, which loads the response register once it is
// free. A query reads the word store one slot per cycle through its single
// registered read port, and the scan ends on a match, on an entry after
// the first whose second letter is above the query's, or at the end of the
// bucket. The core returns to IDLE as a response is loaded and takes no
// new request until then. A bucket's size field reaches 16383 words, more
// than the 8192 slots of the store, and slot addresses wrap around it.
// A finished response waits in the output register while the receiver
// stalls; the core finishes one more request and holds it until that
// register is free. Reset clears the bucket table and the handshake state;
// the word store is not cleared and must be written first.
module bucketed_word_membership_check_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [1:0]                    i_mode,
    input  logic [bwmc_pkg::LETTER_W-1:0] i_letter_index,
    input  logic [bwmc_pkg::SLOT_W-1:0]   i_slot_address,
    input  logic [bwmc_pkg::COUNT_W-1:0]  i_bucket_size,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_first_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_second_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_third_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_fourth_char,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic                          o_found,
    output logic [1:0]                    o_mode_echo
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [bwmc_pkg::SLOT_W-1:0]   r_start;
    logic [bwmc_pkg::COUNT_W-1:0]  r_count;
    logic [bwmc_pkg::COUNT_W-1:0]  r_issue_idx;
    logic [bwmc_pkg::COUNT_W-1:0]  r_chk_idx;
    logic                          r_rd_pend;
    logic [bwmc_pkg::WORD_W-1:0]   r_key;
    logic                          r_res_found;
    logic [1:0]                    r_res_mode;
    logic                          r_o_valid;
    logic                          r_o_found;
    logic [1:0]                    r_o_mode;

    logic                          w_accept;
    logic [bwmc_pkg::CHAR_W-1:0]   w_bucket;
    logic                          w_letter_ok;
    bwmc_pkg::t_desc_wr            w_desc_wr;
    bwmc_pkg::t_desc               w_desc;
    logic [bwmc_pkg::WORD_W-1:0]   w_in_word;
    logic                          w_rd_en;
    logic [bwmc_pkg::ADDR_W-1:0]   w_rd_addr;
    logic [bwmc_pkg::WORD_W-1:0]   w_rd_data;
    logic                          w_out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_in_word   = {i_second_char, i_third_char, i_fourth_char};
    assign w_out_free  = !r_o_valid || i_rsp_ready;

    // Bucket selection from the first character.
    assign w_bucket    = i_first_char - bwmc_pkg::CHAR_A;
    assign w_letter_ok = (i_first_char >= bwmc_pkg::CHAR_A) &&
                         (i_first_char <= bwmc_pkg::CHAR_Z) &&
                         (w_bucket < bwmc_pkg::CHAR_W'(bwmc_pkg::LETTER_COUNT));

    // Descriptor write command for the bucket table.
    always_comb begin
        w_desc_wr.en         = w_accept && (i_mode == bwmc_pkg::MODE_DESC);
        w_desc_wr.letter     = i_letter_index;
        w_desc_wr.desc.start = i_slot_address;
        w_desc_wr.desc.count = i_bucket_size;
    end

    bwmc_bucket_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_desc_wr),
        .i_rd_letter (w_bucket[bwmc_pkg::LETTER_W-1:0]),
        .o_rd_desc   (w_desc)
    );

    // Scan issues one read per cycle while entries of the bucket remain.
    assign w_rd_en   = (r_state == S_SCAN) && (r_issue_idx < r_count);
    assign w_rd_addr = bwmc_pkg::ADDR_W'(r_start + r_issue_idx[bwmc_pkg::SLOT_W-1:0]);

    bwmc_word_ram #(
        .DEPTH  (bwmc_pkg::WORD_SLOTS),
        .WIDTH  (bwmc_pkg::WORD_W),
        .ADDR_W (bwmc_pkg::ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_mode == bwmc_pkg::MODE_WORD)),
        .i_wr_addr (bwmc_pkg::ADDR_W'(i_slot_address)),
        .i_wr_data (w_in_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Control state machine, scan pointers and the response register.
    // Writes to the store happen only in IDLE, so they never overlap a scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_mode  <= i_mode;
                        r_res_found <= 1'b0;
                        r_key       <= w_in_word;
                        r_start     <= w_desc.start;
                        r_count     <= w_desc.count;
                        r_issue_idx <= '0;
                        r_chk_idx   <= '0;
                        r_rd_pend   <= 1'b0;
                        if ((i_mode == bwmc_pkg::MODE_QUERY) && w_letter_ok &&
                            (w_desc.count != '0)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= w_rd_en;
                    if (w_rd_en) begin
                        r_issue_idx <= r_issue_idx + 1'b1;
                    end
                    if (r_rd_pend) begin
                        if ((r_chk_idx != '0) && (w_rd_data[23:16] > r_key[23:16])) begin
                            r_res_found <= 1'b0;
                            r_state     <= S_DONE;
                        end else if (w_rd_data == r_key) begin
                            r_res_found <= 1'b1;
                            r_state     <= S_DONE;
                        end else if ((r_chk_idx + 1'b1) == r_count) begin
                            r_res_found <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_chk_idx <= r_chk_idx + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_found <= r_res_found;
                        r_o_mode  <= r_res_mode;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_o_valid;
    assign o_found     = r_o_found;
    assign o_mode_echo = r_o_mode;

endmodule

// ===== design/bwmc_checker.sv =====
`timescale 1ns / 1ps

module bwmc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          o_req_ready,
    input  logic [1:0]                    i_mode,
    input  logic [bwmc_pkg::LETTER_W-1:0] i_letter_index,
    input  logic [bwmc_pkg::SLOT_W-1:0]   i_slot_address,
    input  logic [bwmc_pkg::COUNT_W-1:0]  i_bucket_size,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_first_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_second_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_third_char,
    input  logic [bwmc_pkg::CHAR_W-1:0]   i_fourth_char,
    input  logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic                          o_found,
    input  logic [1:0]                    o_mode_echo
);

    // A stalled response keeps its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_found) &&
                                        $stable(o_mode_echo))
        else $error("response changed while stalled");

    // Only a query can report a hit.
    a_found_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_mode_echo != bwmc_pkg::MODE_QUERY) |-> !o_found)
        else $error("hit reported for a non-query request");

    // One request in service: acceptance drops ready on the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while another is in service");

    // Reset leaves no response pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

endmodule

bind bucketed_word_membership_check_core bwmc_checker u_bwmc_checker (.*);
